[rtl/i2cme_pkg.sv]
package i2cme_pkg;

    // Command codes carried on the input tuser field
    localparam logic [2:0] OP_TICK    = 3'd0;
    localparam logic [2:0] OP_START   = 3'd1;
    localparam logic [2:0] OP_RESTART = 3'd2;
    localparam logic [2:0] OP_WRITE   = 3'd3;
    localparam logic [2:0] OP_READ    = 3'd4;
    localparam logic [2:0] OP_STOP    = 3'd5;

    localparam int OP_W      = 3;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 16;
    localparam int UNIT_W     = 16;
    localparam int WAIT_W     = 4;
    localparam int BIT_IDX_W  = 4;

    localparam logic [UNIT_W-1:0] UNIT_TICKS_RESET = 16'd250;
    localparam logic [7:0]        MSB_MASK         = 8'h80;

    // Wait lengths in timing units
    localparam logic [WAIT_W-1:0] WAIT_1 = 4'd1;
    localparam logic [WAIT_W-1:0] WAIT_4 = 4'd4;
    localparam logic [WAIT_W-1:0] WAIT_5 = 4'd5;
    localparam logic [WAIT_W-1:0] WAIT_8 = 4'd8;

    // Output tdata bit positions
    localparam int O_SCL  = 0;
    localparam int O_SDA  = 1;
    localparam int O_BUSY = 2;
    localparam int O_DONE = 3;
    localparam int O_RX   = 4;
    localparam int O_ACK  = 12;
    localparam int O_REJ  = 13;

    // APB register map (byte addresses)
    localparam int          APB_ADDR_W    = 3;
    localparam logic [APB_ADDR_W-1:0] ADDR_UNIT_TICKS = 3'd0;

    typedef enum logic [4:0] {
        PH_IDLE = 5'd0,
        PH_ST0  = 5'd1,
        PH_ST1  = 5'd2,
        PH_RS0  = 5'd3,
        PH_RS1  = 5'd4,
        PH_RS2  = 5'd5,
        PH_WB0  = 5'd6,
        PH_WB1  = 5'd7,
        PH_WB2  = 5'd8,
        PH_WA0  = 5'd9,
        PH_WA1  = 5'd10,
        PH_WA2  = 5'd11,
        PH_RB0  = 5'd12,
        PH_RB1  = 5'd13,
        PH_RD0  = 5'd14,
        PH_RD1  = 5'd15,
        PH_RD2  = 5'd16,
        PH_AK0  = 5'd17,
        PH_AK1  = 5'd18,
        PH_AK2  = 5'd19,
        PH_NK0  = 5'd20,
        PH_NK1  = 5'd21,
        PH_NK2  = 5'd22,
        PH_NK3  = 5'd23,
        PH_SP0  = 5'd24,
        PH_SP1  = 5'd25
    } t_phase;

endpackage

[rtl/i2c_master_byte_engine_core.sv]
// I2C master byte engine. Every accepted input transaction is one tick of
// the bit timer. While the engine is idle, the tuser command may start a
// sequence (start, repeated start, write byte, read byte + ACK/NACK, stop);
// the engine then walks its SCL/SDA drive steps, each step waiting a whole
// number of timing units of unit_ticks ticks (register at byte address 0,
// reset 250, 0 behaves as 1). Each input transaction yields exactly one
// output transaction with the line drive and status after that tick.
// Rate: one transaction per cycle unless stalled; the result is registered
// in the single output register, the only stage, so input stalls only when
// that register is full and the sink holds i_m_axis_tready low.
// Commands arriving while busy (including the finishing tick) are dropped
// and flagged with cmd_rejected. Write unit_ticks only while idle.
module i2c_master_byte_engine_core
    import i2cme_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input stream
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // [7:0] tx_byte, [8] send_ack, [9] sda_in, [15:10] zero
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // [2:0] op
    input  logic [OP_W-1:0]       i_s_axis_tuser,
    // output stream
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // [0] scl_level, [1] sda_level, [2] busy_res, [3] done_res,
    // [11:4] rx_byte, [12] ack_received, [13] cmd_rejected, [15:14] zero
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    // APB configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    // engine state
    t_phase               r_phase, n_phase;
    logic [BIT_IDX_W-1:0] r_bit_index, n_bit_index;
    logic [7:0]           r_shift, n_shift;
    logic [UNIT_W-1:0]    r_tick, n_tick;
    logic [WAIT_W-1:0]    r_units, n_units;
    logic                 r_ack_mode, n_ack_mode;
    logic                 r_ack_flag, n_ack_flag;
    logic                 r_scl, n_scl;
    logic                 r_sda, n_sda;
    logic [7:0]           r_rx_hold, n_rx_hold;
    logic [UNIT_W-1:0]    r_unit_ticks;

    // output register
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    logic                  in_accept;
    logic                  n_done;
    logic                  n_rejected;
    logic [OUT_DATA_W-1:0] n_out_data;

    logic [OP_W-1:0] op;
    logic [7:0]      tx_byte;
    logic            send_ack;
    logic            sda_in;

    assign op       = i_s_axis_tuser;
    assign tx_byte  = i_s_axis_tdata[7:0];
    assign send_ack = i_s_axis_tdata[8];
    assign sda_in   = i_s_axis_tdata[9];

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // ---------------- APB ----------------
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_UNIT_TICKS) ? {16'd0, r_unit_ticks} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit_ticks <= UNIT_TICKS_RESET;
        end else if (psel && penable && pwrite && pready && paddr == ADDR_UNIT_TICKS) begin
            r_unit_ticks <= pwdata[UNIT_W-1:0];
        end
    end

    // ---------------- tick logic ----------------
    always_comb begin
        logic [UNIT_W-1:0]    unit;
        logic [UNIT_W-1:0]    tc;
        logic                 go;
        t_phase               step;
        t_phase               nxt;
        logic [WAIT_W-1:0]    wait_units;
        logic [BIT_IDX_W-1:0] bi;

        n_phase     = r_phase;
        n_bit_index = r_bit_index;
        n_shift     = r_shift;
        n_tick      = r_tick;
        n_units     = r_units;
        n_ack_mode  = r_ack_mode;
        n_ack_flag  = r_ack_flag;
        n_scl       = r_scl;
        n_sda       = r_sda;
        n_rx_hold   = r_rx_hold;
        n_done      = 1'b0;
        n_rejected  = 1'b0;
        go          = 1'b0;
        step        = PH_IDLE;
        nxt         = PH_IDLE;
        wait_units  = WAIT_4;
        bi          = r_bit_index + 1'b1;
        unit        = (r_unit_ticks == '0) ? {{(UNIT_W-1){1'b0}}, 1'b1} : r_unit_ticks;
        tc          = r_tick + 1'b1;

        if (r_phase == PH_IDLE) begin
            n_bit_index = '0;
            case (op)
                OP_START: begin
                    go   = 1'b1;
                    step = PH_ST0;
                end
                OP_RESTART: begin
                    go   = 1'b1;
                    step = PH_RS0;
                end
                OP_WRITE: begin
                    n_shift = tx_byte;
                    go      = 1'b1;
                    step    = PH_WB0;
                end
                OP_READ: begin
                    n_shift    = 8'd0;
                    n_ack_mode = send_ack;
                    go         = 1'b1;
                    step       = PH_RB0;
                end
                OP_STOP: begin
                    go   = 1'b1;
                    step = PH_SP0;
                end
                default: ;
            endcase
        end else begin
            n_rejected = (op != OP_TICK);
            if (tc >= unit) begin
                n_tick = '0;
                if (r_units <= WAIT_1) begin
                    // successor step; bit loops advance here
                    case (r_phase)
                        PH_ST0: nxt = PH_ST1;
                        PH_RS0: nxt = PH_RS1;
                        PH_RS1: nxt = PH_RS2;
                        PH_WB0: nxt = PH_WB1;
                        PH_WB1: nxt = PH_WB2;
                        PH_WB2: begin
                            n_shift     = {r_shift[6:0], 1'b0};
                            n_bit_index = bi;
                            nxt         = (bi < BIT_IDX_W'(8)) ? PH_WB0 : PH_WA0;
                        end
                        PH_WA0: nxt = PH_WA1;
                        PH_WA1: nxt = PH_WA2;
                        PH_RB0: nxt = PH_RB1;
                        PH_RB1: nxt = PH_RD0;
                        PH_RD0: nxt = PH_RD1;
                        PH_RD1: nxt = PH_RD2;
                        PH_RD2: begin
                            n_bit_index = bi;
                            if (bi < BIT_IDX_W'(8)) begin
                                nxt = PH_RD0;
                            end else begin
                                nxt = r_ack_mode ? PH_AK0 : PH_NK0;
                            end
                        end
                        PH_AK0: nxt = PH_AK1;
                        PH_AK1: nxt = PH_AK2;
                        PH_NK0: nxt = PH_NK1;
                        PH_NK1: nxt = PH_NK2;
                        PH_NK2: nxt = PH_NK3;
                        PH_SP0: nxt = PH_SP1;
                        default: nxt = PH_IDLE;
                    endcase
                    n_units = '0;
                    if (nxt == PH_IDLE) begin
                        if (r_phase == PH_AK2 || r_phase == PH_NK3) begin
                            n_rx_hold = n_shift;
                        end
                        n_phase = PH_IDLE;
                        n_done  = 1'b1;
                    end else begin
                        go   = 1'b1;
                        step = nxt;
                    end
                end else begin
                    n_units = r_units - 1'b1;
                end
            end else begin
                n_tick = tc;
            end
        end

        // step entry: line changes happen on the first tick of the step
        if (go) begin
            case (step)
                PH_ST1: n_sda = 1'b0;
                PH_RS0: n_sda = 1'b1;
                PH_RS1: n_scl = 1'b1;
                PH_RS2: n_sda = 1'b0;
                PH_WB0: n_scl = 1'b0;
                PH_WB1: n_sda = |(n_shift & MSB_MASK);
                PH_WB2: begin
                    n_scl      = 1'b1;
                    wait_units = WAIT_8;
                end
                PH_WA0: begin
                    n_scl      = 1'b0;
                    n_sda      = 1'b1;
                    wait_units = WAIT_8;
                end
                PH_WA1: begin
                    n_scl      = 1'b1;
                    n_ack_flag = !sda_in;   // slave pulls low to ACK
                    wait_units = WAIT_8;
                end
                PH_WA2: begin
                    n_scl      = 1'b0;
                    n_sda      = 1'b0;
                    wait_units = WAIT_8;
                end
                PH_RB0: n_scl = 1'b0;
                PH_RB1: n_sda = 1'b1;
                PH_RD0: n_scl = 1'b1;
                PH_RD1: n_shift = {n_shift[6:0], sda_in};
                PH_RD2: begin
                    n_scl      = 1'b0;
                    wait_units = WAIT_8;
                end
                PH_AK0: n_sda = 1'b0;
                PH_AK1: begin
                    n_scl      = 1'b1;
                    wait_units = WAIT_8;
                end
                PH_AK2: begin
                    n_scl      = 1'b0;
                    wait_units = WAIT_8;
                end
                PH_NK0: begin
                    n_sda      = 1'b1;
                    wait_units = WAIT_1;
                end
                PH_NK1: begin
                    n_scl      = 1'b1;
                    wait_units = WAIT_5;
                end
                PH_NK2: begin
                    n_scl      = 1'b0;
                    wait_units = WAIT_1;
                end
                PH_NK3: n_sda = 1'b0;
                PH_SP0: n_scl = 1'b1;
                PH_SP1: n_sda = 1'b1;
                default: ;
            endcase
            n_phase = step;
            n_units = wait_units;
            n_tick  = '0;
        end
    end

    always_comb begin
        n_out_data                 = '0;
        n_out_data[O_SCL]          = n_scl;
        n_out_data[O_SDA]          = n_sda;
        n_out_data[O_BUSY]         = (n_phase != PH_IDLE);
        n_out_data[O_DONE]         = n_done;
        n_out_data[O_RX +: 8]      = n_rx_hold;
        n_out_data[O_ACK]          = n_ack_flag;
        n_out_data[O_REJ]          = n_rejected;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_bit_index <= '0;
            r_shift     <= '0;
            r_tick      <= '0;
            r_units     <= '0;
            r_ack_mode  <= 1'b0;
            r_ack_flag  <= 1'b0;
            r_scl       <= 1'b1;
            r_sda       <= 1'b1;
            r_rx_hold   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_phase     <= n_phase;
                r_bit_index <= n_bit_index;
                r_shift     <= n_shift;
                r_tick      <= n_tick;
                r_units     <= n_units;
                r_ack_mode  <= n_ack_mode;
                r_ack_flag  <= n_ack_flag;
                r_scl       <= n_scl;
                r_sda       <= n_sda;
                r_rx_hold   <= n_rx_hold;
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_data <= n_out_data;
        end
    end

endmodule

[rtl/i2cme_checker.sv]
module i2cme_checker
    import i2cme_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_s_axis_tvalid,
    input logic                  o_s_axis_tready,
    input logic                  o_m_axis_tvalid,
    input logic                  i_m_axis_tready,
    input logic [OUT_DATA_W-1:0] o_m_axis_tdata
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result changed while stalled");

    // input side only stalls behind a full, blocked output register
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> o_m_axis_tvalid && !i_m_axis_tready)
        else $error("input stalled without back pressure");

    // each accepted transaction produces a result next cycle
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> o_m_axis_tvalid)
        else $error("no result after accepted transaction");

    // finishing tick reports idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[O_DONE] |-> !o_m_axis_tdata[O_BUSY])
        else $error("done while still busy");

endmodule

bind i2c_master_byte_engine_core i2cme_checker u_i2cme_checker (.*);
